### rtl/core/multihart_fetch_stage_unit_macros.svh
// assertion helpers for the fetch stage top level
`ifndef MULTIHART_FETCH_STAGE_UNIT_MACROS_SVH
`define MULTIHART_FETCH_STAGE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MFS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fetch stage check failed");

// antecedent implies consequent in the cycle after
`define MFS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fetch stage check failed");

`endif

### rtl/core/mfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfs_pkg;

  // default configuration
  localparam int MfsHartCount    = 4;
  localparam int MfsCodeAddrBits = 16;

  // field widths
  localparam int PcW      = 16;
  localparam int HartW    = 2;
  localparam int WordW    = 32;
  localparam int BusyW    = 4;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // queue depths
  localparam int MidDepth = 2;
  localparam int ResDepth = 4;

  typedef enum logic [OpW-1:0] {
    OP_INIT = 2'd0,
    OP_LOAD = 2'd1,
    OP_STEP = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RUNNING   = 3'd0,
    CFG_START_PC0 = 3'd1
  } cfg_idx_e;

  typedef enum logic {
    REQ_FETCH = 1'b0,
    REQ_LOAD  = 1'b1
  } req_kind_e;

  // request handed from front to back
  typedef struct packed {
    req_kind_e          kind;
    logic               fetch;
    logic [HartW-1:0]   hart;
    logic [PcW-1:0]     addr;
    logic [WordW-1:0]   word;
  } mfs_req_t;

  // one result
  typedef struct packed {
    logic               valid;
    logic [HartW-1:0]   hart;
    logic [PcW-1:0]     pc;
    logic [WordW-1:0]   instr;
  } mfs_res_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic res_push;
    logic res_full;
  } mfs_back_stat_t;

endpackage

`default_nettype wire

### rtl/core/mfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mfs_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/mfs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mfs_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [Width-1:0]           rdata_o,
  output logic                            empty_o,
  output logic                            full_o,
  output logic      [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] data_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];
  assign count_o = cnt_q;

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mfs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mfs_front import mfs_pkg::*; #(
  parameter int HartCount = MfsHartCount
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push_i,
  input  wire logic                queue_full_i,
  input  wire logic [OpW-1:0]      operation_i,
  input  wire logic                decode_valid_i,
  input  wire logic [HartW-1:0]    decode_hart_i,
  input  wire logic [PcW-1:0]      decode_pc_i,
  input  wire logic                exec_valid_i,
  input  wire logic [HartW-1:0]    exec_hart_i,
  input  wire logic [PcW-1:0]      exec_pc_i,
  input  wire logic [BusyW-1:0]    decode_busy_i,
  input  wire logic [PcW-1:0]      code_addr_i,
  input  wire logic [WordW-1:0]    code_word_i,
  output logic                     req_push_o,
  output mfs_req_t                 req_o
);

  logic [HartCount-1:0] running_q;
  logic [PcW-1:0]       start_pc_q [HartCount];
  logic [PcW-1:0]       pc_q       [HartCount];
  logic [PcW-1:0]       pc_d       [HartCount];
  logic [HartCount-1:0] pend_q, pend_d;

  logic             accept;
  logic             d_ok, e_ok;
  logic             picked;
  logic [HartW-1:0] pick;
  logic             fetch;
  logic [HartW-1:0] fh;
  logic [PcW-1:0]   fpc;

  assign accept = push_i && !queue_full_i;
  assign d_ok   = decode_valid_i && (int'(decode_hart_i) < HartCount);
  assign e_ok   = exec_valid_i && (int'(exec_hart_i) < HartCount);

  // lowest pending hart with a free decode slot, on the old pending bits
  always_comb begin
    picked = 1'b0;
    pick   = '0;
    for (int h = HartCount - 1; h >= 0; h--) begin
      if (pend_q[h] && !decode_busy_i[h]) begin
        picked = 1'b1;
        pick   = HartW'(h);
      end
    end
  end

  // fetch choice with decode then execute as fallback
  always_comb begin
    fetch = 1'b1;
    fh    = '0;
    if (picked) begin
      fh = pick;
    end else if (d_ok && !decode_busy_i[decode_hart_i]) begin
      fh = decode_hart_i;
    end else if (e_ok && !decode_busy_i[exec_hart_i]) begin
      fh = exec_hart_i;
    end else begin
      fetch = 1'b0;
    end
  end

  // new pcs and pending bits, execute wins over decode
  always_comb begin
    fpc = '0;
    for (int h = 0; h < HartCount; h++) begin
      pc_d[h]   = pc_q[h];
      pend_d[h] = pend_q[h];
      if (e_ok && (exec_hart_i == HartW'(h))) begin
        pc_d[h]   = exec_pc_i;
        pend_d[h] = 1'b1;
      end else if (d_ok && (decode_hart_i == HartW'(h))) begin
        pc_d[h]   = decode_pc_i;
        pend_d[h] = 1'b1;
      end
      if (fetch && (fh == HartW'(h))) begin
        pend_d[h] = 1'b0;
        fpc       = pc_d[h];
      end
    end
  end

  // request towards the back end
  assign req_push_o = accept &&
                      ((operation_i == OP_STEP) || (operation_i == OP_LOAD));

  always_comb begin
    req_o       = '0;
    req_o.word  = code_word_i;
    if (operation_i == OP_LOAD) begin
      req_o.kind = REQ_LOAD;
      req_o.addr = code_addr_i;
    end else begin
      req_o.kind  = REQ_FETCH;
      req_o.fetch = fetch;
      req_o.hart  = fh;
      req_o.addr  = fpc;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= HartCount'(1);
      for (int h = 0; h < HartCount; h++) begin
        start_pc_q[h] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_RUNNING) begin
        running_q <= cfg_data_i[HartCount-1:0];
      end
      for (int h = 0; h < HartCount; h++) begin
        if (int'(cfg_idx_i) == int'(CFG_START_PC0) + h) begin
          start_pc_q[h] <= cfg_data_i[PcW-1:0];
        end
      end
    end
  end

  // hart state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      for (int h = 0; h < HartCount; h++) begin
        pc_q[h] <= '0;
      end
    end else if (accept) begin
      case (operation_i)
        OP_INIT: begin
          pend_q <= running_q;
          for (int h = 0; h < HartCount; h++) begin
            pc_q[h] <= start_pc_q[h];
          end
        end
        OP_STEP: begin
          pend_q <= pend_d;
          for (int h = 0; h < HartCount; h++) begin
            pc_q[h] <= pc_d[h];
          end
        end
        default: begin
          pend_q <= pend_q;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/mfs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mfs_back import mfs_pkg::*; #(
  parameter int CodeAddrBits = MfsCodeAddrBits
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_empty_i,
  input  wire mfs_req_t       req_i,
  output logic                req_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output mfs_res_t            res_o,
  output mfs_back_stat_t      stat_o
);

  localparam int ResCntW = $clog2(ResDepth + 1);
  localparam int ResW    = $bits(mfs_res_t);

  logic [CodeAddrBits-1:0] mem_addr;
  logic [WordW-1:0]        rdata;
  logic                    space;
  logic                    is_load;
  logic                    mem_we;
  logic                    stage_valid_q, stage_valid_d;
  logic                    stage_fetch_q;
  logic [HartW-1:0]        stage_hart_q;
  logic [PcW-1:0]          stage_pc_q;
  mfs_res_t                res_in;
  logic [ResW-1:0]         res_out;
  logic                    res_full;
  logic [ResCntW-1:0]      res_cnt;

  // word address from the low pc bits
  if (CodeAddrBits <= PcW) begin : g_addr_narrow
    assign mem_addr = req_i.addr[CodeAddrBits-1:0];
  end else begin : g_addr_wide
    assign mem_addr = {{(CodeAddrBits - PcW){1'b0}}, req_i.addr};
  end

  // steps issue only with room for the result in flight; loads need no room
  assign space         = (int'(res_cnt) + int'(stage_valid_q)) < ResDepth;
  assign is_load       = (req_i.kind == REQ_LOAD);
  assign req_pop_o     = !req_empty_i && (is_load || space);
  assign mem_we        = req_pop_o && is_load;
  assign stage_valid_d = req_pop_o && !is_load;

  mfs_ram #(
    .Width (WordW),
    .Depth (2 ** CodeAddrBits)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (req_i.word),
    .raddr_i (mem_addr),
    .rdata_o (rdata)
  );

  // read stage beside the memory access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_valid_d) begin
      stage_fetch_q <= req_i.fetch;
      stage_hart_q  <= req_i.hart;
      stage_pc_q    <= req_i.addr;
    end
  end

  // result assembly, zeros when nothing was fetched
  always_comb begin
    res_in.valid = stage_fetch_q;
    res_in.hart  = stage_hart_q;
    res_in.pc    = stage_pc_q;
    res_in.instr = stage_fetch_q ? rdata : '0;
  end

  mfs_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stage_valid_q),
    .wdata_i (res_in),
    .pop_i   (pop_i),
    .rdata_o (res_out),
    .empty_o (empty_o),
    .full_o  (res_full),
    .count_o (res_cnt)
  );

  assign res_o           = res_out;
  assign stat_o.res_push = stage_valid_q;
  assign stat_o.res_full = res_full;

endmodule

`default_nettype wire

### rtl/core/multihart_fetch_stage_unit.sv
// channel   | direction | handshake        | payload
// ----------+-----------+------------------+--------------------------------------------
// config    | in        | cfg_we_i         | cfg_idx_i, cfg_data_i
// request   | in        | push / full      | operation_i, decode_*, exec_*, code_*
// result    | out       | empty / pop      | out_valid_o, out_hart_o, out_pc_o, out_instruction_o
//
// one request per cycle unless stalled; a step passes request queue, read stage, result queue
// throughput set by the single code ram address, shared by loads and fetch reads
// front updates hart pcs and pending bits at acceptance; back reads the code ram in order
// reset clears hart state and queues; code ram is not cleared, no start-up pass
// full rises when the two-entry request queue is full; back stalls when results back up
`timescale 1ns / 1ps
`default_nettype none
`include "multihart_fetch_stage_unit_macros.svh"

module multihart_fetch_stage_unit import mfs_pkg::*; #(
  parameter int HartCount    = MfsHartCount,
  parameter int CodeAddrBits = MfsCodeAddrBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [OpW-1:0]      operation_i,
  input  wire logic                decode_valid_i,
  input  wire logic [HartW-1:0]    decode_hart_i,
  input  wire logic [PcW-1:0]      decode_pc_i,
  input  wire logic                exec_valid_i,
  input  wire logic [HartW-1:0]    exec_hart_i,
  input  wire logic [PcW-1:0]      exec_pc_i,
  input  wire logic [BusyW-1:0]    decode_busy_i,
  input  wire logic [PcW-1:0]      code_addr_i,
  input  wire logic [WordW-1:0]    code_word_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     out_valid_o,
  output logic      [HartW-1:0]    out_hart_o,
  output logic      [PcW-1:0]      out_pc_o,
  output logic      [WordW-1:0]    out_instruction_o
);

  localparam int MidW    = $bits(mfs_req_t);
  localparam int MidCntW = $clog2(MidDepth + 1);

  logic               req_push;
  mfs_req_t           req_in;
  logic [MidW-1:0]    mid_head;
  logic               mid_empty;
  logic               mid_pop;
  logic [MidCntW-1:0] mid_count;
  mfs_res_t           res;
  mfs_back_stat_t     back_stat;
  logic               in_acc;

  // front: hart state and request classification
  mfs_front #(
    .HartCount (HartCount)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push_i         (push),
    .queue_full_i   (full),
    .operation_i    (operation_i),
    .decode_valid_i (decode_valid_i),
    .decode_hart_i  (decode_hart_i),
    .decode_pc_i    (decode_pc_i),
    .exec_valid_i   (exec_valid_i),
    .exec_hart_i    (exec_hart_i),
    .exec_pc_i      (exec_pc_i),
    .decode_busy_i  (decode_busy_i),
    .code_addr_i    (code_addr_i),
    .code_word_i    (code_word_i),
    .req_push_o     (req_push),
    .req_o          (req_in)
  );

  // decoupling queue between front and back
  mfs_fifo #(
    .Width (MidW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .wdata_i (req_in),
    .pop_i   (mid_pop),
    .rdata_o (mid_head),
    .empty_o (mid_empty),
    .full_o  (full),
    .count_o (mid_count)
  );

  // back: code memory and result queue
  mfs_back #(
    .CodeAddrBits (CodeAddrBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_empty_i (mid_empty),
    .req_i       (mid_head),
    .req_pop_o   (mid_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res),
    .stat_o      (back_stat)
  );

  assign out_valid_o       = res.valid;
  assign out_hart_o        = res.hart;
  assign out_pc_o          = res.pc;
  assign out_instruction_o = res.instr;

  // request taken at this edge
  assign in_acc = push && !full;

  // result queue never overflows thanks to issue credit
  `MFS_ASSERT_IMPL(a_res_no_overflow, back_stat.res_push, !back_stat.res_full)
  // an accepted step always leaves a request queued
  `MFS_ASSERT_NEXT(a_step_queued, in_acc && (operation_i == OP_STEP), !mid_empty)
  // init never adds a request
  `MFS_ASSERT_NEXT(a_init_no_req, in_acc && (operation_i == OP_INIT), mid_count <= $past(mid_count))

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mfs_pkg::*;

  // operation code the block ignores
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam mfs_res_t NoFetch = '0;
  localparam int ItemsPerPhase = 450;

  // one request as offered on the input side
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             decode_valid;
    logic [HartW-1:0] decode_hart;
    logic [PcW-1:0]   decode_pc;
    logic             exec_valid;
    logic [HartW-1:0] exec_hart;
    logic [PcW-1:0]   exec_pc;
    logic [BusyW-1:0] decode_busy;
    logic [PcW-1:0]   code_addr;
    logic [WordW-1:0] code_word;
  } fetch_item_t;

  // directed row, with the result typed in where it is obvious
  typedef struct packed {
    fetch_item_t item;
    logic        typed;
    mfs_res_t    res;
  } directed_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push;
  logic                full;
  logic [OpW-1:0]      operation_i;
  logic                decode_valid_i;
  logic [HartW-1:0]    decode_hart_i;
  logic [PcW-1:0]      decode_pc_i;
  logic                exec_valid_i;
  logic [HartW-1:0]    exec_hart_i;
  logic [PcW-1:0]      exec_pc_i;
  logic [BusyW-1:0]    decode_busy_i;
  logic [PcW-1:0]      code_addr_i;
  logic [WordW-1:0]    code_word_i;
  logic                empty;
  logic                pop;
  logic                out_valid_o;
  logic [HartW-1:0]    out_hart_o;
  logic [PcW-1:0]      out_pc_o;
  logic [WordW-1:0]    out_instruction_o;

  // predictor state
  logic [3:0]          running_mask;
  logic [PcW-1:0]      start_pcs [4];
  logic [PcW-1:0]      hart_fetch_pc [4];
  logic                hart_armed [4];
  logic [WordW-1:0]    code_image [logic [PcW-1:0]];
  logic [PcW-1:0]      loaded_addrs [$];
  mfs_res_t            expected_fetches [$];
  mfs_res_t            oldest_fetch;

  // run control and tallies
  bit no_idle = 1'b0;
  int hold_cycles = 0;
  int n_steps = 0, n_fetches = 0, n_loads = 0, n_inits = 0, n_ignored = 0;
  int n_checked = 0, n_failures = 0;

  multihart_fetch_stage_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .push              (push),
    .full              (full),
    .operation_i       (operation_i),
    .decode_valid_i    (decode_valid_i),
    .decode_hart_i     (decode_hart_i),
    .decode_pc_i       (decode_pc_i),
    .exec_valid_i      (exec_valid_i),
    .exec_hart_i       (exec_hart_i),
    .exec_pc_i         (exec_pc_i),
    .decode_busy_i     (decode_busy_i),
    .code_addr_i       (code_addr_i),
    .code_word_i       (code_word_i),
    .empty             (empty),
    .pop               (pop),
    .out_valid_o       (out_valid_o),
    .out_hart_o        (out_hart_o),
    .out_pc_o          (out_pc_o),
    .out_instruction_o (out_instruction_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cycles of idling before the next request or pop
  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // any word address that already holds code
  function automatic logic [PcW-1:0] loaded_pc();
    return loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
  endfunction

  // fetch stage behaviour: updates hart state, returns 1 when a result is due
  function automatic bit predict_fetch(input fetch_item_t it, output mfs_res_t res);
    int h;
    bit picked;
    bit fetching;
    logic [HartW-1:0] pick;
    logic [HartW-1:0] fh;
    res = NoFetch;
    picked = 1'b0;
    pick = '0;
    fh = '0;
    case (it.op)
      OP_INIT: begin
        for (h = 0; h < 4; h++) begin
          hart_armed[h] = running_mask[h];
          hart_fetch_pc[h] = start_pcs[h];
        end
        n_inits++;
        return 1'b0;
      end
      OP_LOAD: begin
        if (!code_image.exists(it.code_addr)) loaded_addrs.push_back(it.code_addr);
        code_image[it.code_addr] = it.code_word;
        n_loads++;
        return 1'b0;
      end
      OP_STEP: begin
        // lowest armed hart with a free decode slot, from the old pending bits
        for (h = 0; h < 4; h++) begin
          if (!picked && hart_armed[h] && !it.decode_busy[h]) begin
            picked = 1'b1;
            pick = HartW'(h);
          end
        end
        // redirects, execute after decode so it wins on the same hart
        if (it.decode_valid) begin
          hart_armed[it.decode_hart] = 1'b1;
          hart_fetch_pc[it.decode_hart] = it.decode_pc;
        end
        if (it.exec_valid) begin
          hart_armed[it.exec_hart] = 1'b1;
          hart_fetch_pc[it.exec_hart] = it.exec_pc;
        end
        // fall back to the decode hart, then the execute hart
        fetching = 1'b1;
        if (picked) fh = pick;
        else if (it.decode_valid && !it.decode_busy[it.decode_hart]) fh = it.decode_hart;
        else if (it.exec_valid && !it.decode_busy[it.exec_hart]) fh = it.exec_hart;
        else fetching = 1'b0;
        if (fetching) begin
          hart_armed[fh] = 1'b0;
          res.valid = 1'b1;
          res.hart = fh;
          res.pc = hart_fetch_pc[fh];
          res.instr = code_image.exists(res.pc) ? code_image[res.pc] : '0;
          n_fetches++;
        end
        n_steps++;
        return 1'b1;
      end
      default: begin
        n_ignored++;
        return 1'b0;
      end
    endcase
  endfunction

  // offer one request, wait for acceptance, then log what it should produce
  task automatic offer_item(input fetch_item_t it, input logic typed, input mfs_res_t typed_res);
    int gap;
    mfs_res_t res;
    gap = idle_draw();
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    operation_i    <= it.op;
    decode_valid_i <= it.decode_valid;
    decode_hart_i  <= it.decode_hart;
    decode_pc_i    <= it.decode_pc;
    exec_valid_i   <= it.exec_valid;
    exec_hart_i    <= it.exec_hart;
    exec_pc_i      <= it.exec_pc;
    decode_busy_i  <= it.decode_busy;
    code_addr_i    <= it.code_addr;
    code_word_i    <= it.code_word;
    push           <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (predict_fetch(it, res)) expected_fetches.push_back(typed ? typed_res : res);
  endtask

  // write the running mask and all start pcs while the block is idle
  task automatic program_harts(input logic [3:0] mask, input logic [3:0][PcW-1:0] starts);
    int i;
    for (i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      if (i == 0) begin
        cfg_idx_i  <= CFG_RUNNING;
        cfg_data_i <= CfgDataW'(mask);
      end else begin
        cfg_idx_i  <= CfgIdxW'(CFG_START_PC0 + i - 1);
        cfg_data_i <= starts[i-1];
      end
      @(posedge clk_i);
      if (i == 0) running_mask = mask;
      else start_pcs[i-1] = starts[i-1];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stop offering and wait until every expected result is out
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_fetches.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic directed_row_t row(
    input logic [OpW-1:0] op, input logic dv, input logic [HartW-1:0] dh,
    input logic [PcW-1:0] dpc, input logic ev, input logic [HartW-1:0] eh,
    input logic [PcW-1:0] epc, input logic [BusyW-1:0] busy,
    input logic [PcW-1:0] addr, input logic [WordW-1:0] word,
    input logic typed, input mfs_res_t res);
    directed_row_t r;
    r.item = '{op, dv, dh, dpc, ev, eh, epc, busy, addr, word};
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  // mostly well-formed steps over loaded code, some loads, inits and noise
  function automatic fetch_item_t random_item();
    fetch_item_t it;
    int roll;
    it.decode_valid = $urandom;
    it.decode_hart  = $urandom;
    it.decode_pc    = $urandom;
    it.exec_valid   = $urandom;
    it.exec_hart    = $urandom;
    it.exec_pc      = $urandom;
    it.decode_busy  = $urandom;
    it.code_addr    = $urandom;
    it.code_word    = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 9) it.op = OP_LOAD;
    else if (roll < 12) it.op = OP_INIT;
    else if (roll < 14) it.op = OpUnused;
    else begin
      it.op = OP_STEP;
      it.decode_valid = ($urandom_range(0, 9) < 7);
      it.exec_valid   = ($urandom_range(0, 9) < 3);
      if (it.decode_valid) it.decode_pc = loaded_pc();
      if (it.exec_valid) it.exec_pc = loaded_pc();
      if ($urandom_range(0, 1) == 0) it.decode_busy = '0;
    end
    return it;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_fetches.size() == 0) begin
        $error("result with no request waiting: valid %0b hart %0d pc %h instruction %h",
               out_valid_o, out_hart_o, out_pc_o, out_instruction_o);
        n_failures++;
      end else begin
        oldest_fetch = expected_fetches.pop_front();
        n_checked++;
        if (out_valid_o !== oldest_fetch.valid) begin
          $error("out_valid: expected %0b, got %0b", oldest_fetch.valid, out_valid_o);
          n_failures++;
        end
        if (out_hart_o !== oldest_fetch.hart) begin
          $error("out_hart: expected %0d, got %0d", oldest_fetch.hart, out_hart_o);
          n_failures++;
        end
        if (out_pc_o !== oldest_fetch.pc) begin
          $error("out_pc: expected %h, got %h", oldest_fetch.pc, out_pc_o);
          n_failures++;
        end
        if (out_instruction_o !== oldest_fetch.instr) begin
          $error("out_instruction: expected %h, got %h", oldest_fetch.instr, out_instruction_o);
          n_failures++;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int stall;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_draw();
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // watchdog
  initial begin
    #5000000;
    $display("multihart_fetch_stage_unit test failed");
    $finish;
  end

  // request side
  initial begin : request_side
    directed_row_t rows [$];
    int i;
    int phase;
    int counted;
    bit held;
    logic [3:0] mask;
    logic [3:0][PcW-1:0] starts;
    fetch_item_t it;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    push           = 1'b0;
    operation_i    = '0;
    decode_valid_i = 1'b0;
    decode_hart_i  = '0;
    decode_pc_i    = '0;
    exec_valid_i   = 1'b0;
    exec_hart_i    = '0;
    exec_pc_i      = '0;
    decode_busy_i  = '0;
    code_addr_i    = '0;
    code_word_i    = '0;
    running_mask   = 4'h1;
    for (i = 0; i < 4; i++) begin
      start_pcs[i] = '0;
      hart_fetch_pc[i] = '0;
      hart_armed[i] = 1'b0;
    end
    held = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all harts run, start pcs at the extremes
    program_harts(4'hF, {16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000});

    // directed part
    // nothing pending after reset: no fetch
    rows.push_back(row(OP_STEP, 0, 0, 16'h0000, 0, 0, 16'h0000, 4'h0, 16'h0000, 0, 1, NoFetch));
    rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 32'hFFFF_FFFF, 0, NoFetch));
    rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 32'h0000_0000, 0, NoFetch));
    rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 16'h5555, 32'hA5A5_A5A5, 0, NoFetch));
    rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 16'hAAAA, 32'h5A5A_5A5A, 0, NoFetch));
    rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 32'h1357_9BDF, 0, NoFetch));
    // unknown operation with every field set: ignored
    rows.push_back(row(OpUnused, 1, 3, 16'hFFFF, 1, 3, 16'hFFFF, 4'hF, 16'hFFFF,
                       32'hFFFF_FFFF, 0, NoFetch));
    // idle harts: decode redirect is fetched straight away
    rows.push_back(row(OP_STEP, 1, 3, 16'hFFFF, 0, 0, 0, 4'h0, 0, 0, 1,
                       {1'b1, 2'd3, 16'hFFFF, 32'h0000_0000}));
    rows.push_back(row(OP_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, NoFetch));
    rows.push_back(row(OP_STEP, 0, 0, 0, 0, 0, 0, 4'h0, 0, 0, 1,
                       {1'b1, 2'd0, 16'h0000, 32'hFFFF_FFFF}));
    // busy slot skipped by the pick
    rows.push_back(row(OP_STEP, 0, 0, 0, 0, 0, 0, 4'b0010, 0, 0, 0, NoFetch));
    // every slot busy: no fetch
    rows.push_back(row(OP_STEP, 1, 1, 16'h1234, 0, 0, 0, 4'hF, 0, 0, 1, NoFetch));
    // decode and execute on the same hart, execute pc kept
    rows.push_back(row(OP_STEP, 1, 1, 16'h1234, 1, 1, 16'h5555, 4'h0, 0, 0, 0, NoFetch));
    rows.push_back(row(OP_STEP, 0, 0, 0, 1, 0, 16'h0000, 4'hF, 0, 0, 1, NoFetch));
    rows.push_back(row(OP_STEP, 0, 0, 0, 0, 0, 0, 4'b1110, 0, 0, 0, NoFetch));
    rows.push_back(row(OP_STEP, 0, 0, 0, 0, 0, 0, 4'b0111, 0, 0, 0, NoFetch));
    // decode hart busy: fall back to the execute hart
    rows.push_back(row(OP_STEP, 1, 2, 16'h1234, 1, 1, 16'hAAAA, 4'b0100, 0, 0, 0, NoFetch));
    rows.push_back(row(OP_STEP, 0, 0, 0, 0, 0, 0, 4'h0, 0, 0, 0, NoFetch));
    // overwrite a code word, then fetch it
    rows.push_back(row(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 32'h8000_0001, 0, NoFetch));
    rows.push_back(row(OP_STEP, 1, 0, 16'h0000, 1, 3, 16'hFFFF, 4'h0, 0, 0, 0, NoFetch));
    rows.push_back(row(OP_STEP, 0, 0, 0, 0, 0, 0, 4'b1000, 0, 0, 0, NoFetch));
    rows.push_back(row(OP_STEP, 0, 0, 0, 0, 0, 0, 4'h0, 0, 0, 0, NoFetch));
    foreach (rows[i]) offer_item(rows[i].item, rows[i].typed, rows[i].res);
    drain();

    // random phases, each with its own hart setup
    for (phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: mask = 4'h0;
        4: mask = 4'hF;
        default: mask = $urandom;
      endcase
      if (phase == 4) starts = {loaded_pc(), loaded_pc(), 16'h0000, 16'hFFFF};
      else starts = {loaded_pc(), loaded_pc(), loaded_pc(), loaded_pc()};
      program_harts(mask, starts);
      counted = 0;
      while (counted < ItemsPerPhase) begin
        if (counted % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        // long receiver hold-off while requests keep coming back to back
        if (phase == 2 && counted == 200 && !held) begin
          held = 1'b1;
          no_idle = 1'b1;
          hold_cycles = 90;
        end
        it = random_item();
        offer_item(it, 1'b0, NoFetch);
        if (it.op != OpUnused) counted++;
      end
      no_idle = 1'b0;
      drain();
    end

    $display("covered %0d fetch steps (%0d fetched), %0d code loads, %0d inits, %0d ignored",
             n_steps, n_fetches, n_loads, n_inits, n_ignored);
    $display("%0d results checked over 5 hart setups, %0d mismatches", n_checked, n_failures);
    if (n_failures == 0) begin
      $display("multihart_fetch_stage_unit test passed");
    end else begin
      $display("multihart_fetch_stage_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mfs_pkg.sv
rtl/core/mfs_ram.sv
rtl/core/mfs_fifo.sv
rtl/core/mfs_front.sv
rtl/core/mfs_back.sv
rtl/core/multihart_fetch_stage_unit.sv
verif/testbench.sv
